[rtl/bltm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bltm_pkg
// Shared types and constants of the bracket loop tape machine: transaction
// payloads, action codes, operator characters and default memory depths.
// ----------------------------------------------------------------------------
package bltm_pkg;

  localparam int unsigned ProgDepthDef = 4096;
  localparam int unsigned TapeDepthDef = 2048;

  // Action codes of an input transaction
  localparam logic [1:0] ActLoad    = 2'd0;
  localparam logic [1:0] ActRestart = 2'd1;
  localparam logic [1:0] ActStep    = 2'd2;

  // Operator characters
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharRight = 8'h3E;
  localparam logic [7:0] CharLeft  = 8'h3C;
  localparam logic [7:0] CharInc   = 8'h2B;
  localparam logic [7:0] CharDec   = 8'h2D;
  localparam logic [7:0] CharOut   = 8'h2E;
  localparam logic [7:0] CharOpen  = 8'h5B;
  localparam logic [7:0] CharClose = 8'h5D;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] load_address;
    logic [7:0]  load_char;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       halted;
  } out_t;

endpackage
`default_nettype wire

[rtl/bltm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bltm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bltm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/bltm_outreg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bltm_outreg
// Output register of the result channel. Frees the slot in the same cycle
// that the held transaction leaves.
// ----------------------------------------------------------------------------
module bltm_outreg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bltm_pkg::out_t push_data_i,
  output      logic           free_o,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      bltm_pkg::out_t out_data_o
);
  import bltm_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

[rtl/bltm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bltm_ctrl
// Sequencer of the tape machine: decodes transactions, reads program and tape
// memory, writes back cells, scans for matching brackets and sweeps the tape.
// ----------------------------------------------------------------------------
module bltm_ctrl #(
  parameter int unsigned PROG_DEPTH = bltm_pkg::ProgDepthDef,
  parameter int unsigned TAPE_DEPTH = bltm_pkg::TapeDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire bltm_pkg::in_t                 in_data_i,
  output      logic                          prog_we_o,
  output      logic [$clog2(PROG_DEPTH)-1:0] prog_waddr_o,
  output      logic [7:0]                    prog_wdata_o,
  output      logic [$clog2(PROG_DEPTH)-1:0] prog_raddr_o,
  input  wire logic [7:0]                    prog_rdata_i,
  output      logic                          tape_we_o,
  output      logic [$clog2(TAPE_DEPTH)-1:0] tape_waddr_o,
  output      logic [7:0]                    tape_wdata_o,
  output      logic [$clog2(TAPE_DEPTH)-1:0] tape_raddr_o,
  input  wire logic [7:0]                    tape_rdata_i,
  input  wire logic                          res_free_i,
  output      logic                          res_push_o,
  output      bltm_pkg::out_t                res_o
);
  import bltm_pkg::*;

  localparam int unsigned PA  = $clog2(PROG_DEPTH);
  localparam int unsigned PCW = PA + 1;
  localparam int unsigned DW  = $clog2(TAPE_DEPTH);
  localparam logic [PCW-1:0] PcEnd = PCW'(PROG_DEPTH);
  localparam logic [DW-1:0]  DpMax = DW'(TAPE_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_CLEAR = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic [DW-1:0]  dp_q, dp_d;
  logic           halted_q, halted_d;
  logic [PCW-1:0] scan_addr_q, scan_addr_d;
  logic [PCW-1:0] depth_q, depth_d;
  logic           fwd_q, fwd_d;
  logic [DW-1:0]  clr_q, clr_d;
  logic           clr_resp_q, clr_resp_d;
  out_t           hold_q, hold_d;

  logic           done;
  out_t           res;
  logic [PCW-1:0] pc_inc;
  logic [PCW-1:0] scan_next;
  logic           is_open, is_close, closes;

  assign pc_inc   = pc_q + PCW'(1);
  assign is_open  = (prog_rdata_i == CharOpen);
  assign is_close = (prog_rdata_i == CharClose);
  // Character that lowers the nesting count in the current scan direction
  assign closes   = fwd_q ? is_close : is_open;

  assign prog_waddr_o = PA'(in_data_i.load_address);
  assign prog_wdata_o = in_data_i.load_char;
  assign tape_raddr_o = dp_q;

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    dp_d         = dp_q;
    halted_d     = halted_q;
    scan_addr_d  = scan_addr_q;
    depth_d      = depth_q;
    fwd_d        = fwd_q;
    clr_d        = clr_q;
    clr_resp_d   = clr_resp_q;
    hold_d       = hold_q;
    done         = 1'b0;
    res          = '{out_byte: 8'd0, out_valid: 1'b0, halted: 1'b0};
    in_ready_o   = 1'b0;
    prog_we_o    = 1'b0;
    prog_raddr_o = PA'(pc_q);
    tape_we_o    = 1'b0;
    tape_waddr_o = dp_q;
    tape_wdata_o = 8'd0;
    res_push_o   = 1'b0;
    scan_next    = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_data_i.action)
            ActLoad: begin
              prog_we_o = (32'(in_data_i.load_address) < 32'(PROG_DEPTH));
              done      = 1'b1;
            end
            ActRestart: begin
              pc_d       = '0;
              dp_d       = '0;
              halted_d   = 1'b0;
              clr_d      = '0;
              clr_resp_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            ActStep: begin
              if (halted_q) begin
                done = 1'b1;
              end else if (pc_q >= PcEnd) begin
                halted_d = 1'b1;
                done     = 1'b1;
              end else begin
                // program and tape reads go out at this edge
                state_d = ST_EXEC;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_EXEC: begin
        case (prog_rdata_i)
          CharNul: begin
            halted_d = 1'b1;
            done     = 1'b1;
          end
          CharRight: begin
            dp_d = (dp_q == DpMax) ? '0 : dp_q + DW'(1);
            pc_d = pc_inc;
            done = 1'b1;
          end
          CharLeft: begin
            dp_d = (dp_q == '0) ? DpMax : dp_q - DW'(1);
            pc_d = pc_inc;
            done = 1'b1;
          end
          CharInc: begin
            tape_we_o    = 1'b1;
            tape_wdata_o = tape_rdata_i + 8'd1;
            pc_d         = pc_inc;
            done         = 1'b1;
          end
          CharDec: begin
            tape_we_o    = 1'b1;
            tape_wdata_o = tape_rdata_i - 8'd1;
            pc_d         = pc_inc;
            done         = 1'b1;
          end
          CharOut: begin
            res.out_byte  = tape_rdata_i;
            res.out_valid = 1'b1;
            pc_d          = pc_inc;
            done          = 1'b1;
          end
          CharOpen: begin
            if (tape_rdata_i == 8'd0) begin
              fwd_d   = 1'b1;
              depth_d = PCW'(1);
              if (pc_inc >= PcEnd) begin
                halted_d = 1'b1;
                done     = 1'b1;
              end else begin
                scan_addr_d  = pc_inc;
                prog_raddr_o = PA'(pc_inc);
                state_d      = ST_SCAN;
              end
            end else begin
              pc_d = pc_inc;
              done = 1'b1;
            end
          end
          CharClose: begin
            if (tape_rdata_i != 8'd0) begin
              fwd_d   = 1'b0;
              depth_d = PCW'(1);
              if (pc_q == '0) begin
                halted_d = 1'b1;
                done     = 1'b1;
              end else begin
                scan_addr_d  = pc_q - PCW'(1);
                prog_raddr_o = PA'(pc_q - PCW'(1));
                state_d      = ST_SCAN;
              end
            end else begin
              pc_d = pc_inc;
              done = 1'b1;
            end
          end
          default: begin
            pc_d = pc_inc;
            done = 1'b1;
          end
        endcase
      end

      ST_SCAN: begin
        // read data belongs to scan_addr_q; next read goes out in parallel
        scan_next = fwd_q ? scan_addr_q + PCW'(1) : scan_addr_q - PCW'(1);
        if (fwd_q && prog_rdata_i == CharNul) begin
          halted_d = 1'b1;
          done     = 1'b1;
        end else if (closes && depth_q == PCW'(1)) begin
          pc_d = scan_addr_q + PCW'(1);
          done = 1'b1;
        end else begin
          if (closes) begin
            depth_d = depth_q - PCW'(1);
          end else if (is_open || is_close) begin
            depth_d = depth_q + PCW'(1);
          end
          if (fwd_q ? (scan_next >= PcEnd) : (scan_addr_q == '0)) begin
            halted_d = 1'b1;
            done     = 1'b1;
          end else begin
            scan_addr_d  = scan_next;
            prog_raddr_o = PA'(scan_next);
          end
        end
      end

      ST_CLEAR: begin
        tape_we_o    = 1'b1;
        tape_waddr_o = clr_q;
        if (clr_q == DpMax) begin
          clr_resp_d = 1'b0;
          if (clr_resp_q) begin
            done = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          clr_d = clr_q + DW'(1);
        end
      end

      ST_HOLD: begin
        if (res_free_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res.halted = halted_d;
    if (done) begin
      if (res_free_i) begin
        res_push_o = 1'b1;
        state_d    = ST_IDLE;
      end else begin
        hold_d  = res;
        state_d = ST_HOLD;
      end
    end
    if (state_q == ST_HOLD) begin
      res = hold_q;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      pc_q       <= '0;
      dp_q       <= '0;
      halted_q   <= 1'b0;
      clr_q      <= '0;
      clr_resp_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pc_q       <= pc_d;
      dp_q       <= dp_d;
      halted_q   <= halted_d;
      clr_q      <= clr_d;
      clr_resp_q <= clr_resp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    depth_q     <= depth_d;
    fwd_q       <= fwd_d;
    hold_q      <= hold_d;
  end

endmodule
`default_nettype wire

[rtl/bracket_loop_tape_machine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Load: result registered on the accepting edge when the output register is free, else held.
// Step: program and tape read, then execute and write back.
// Bracket jump: read and execute as for a step, then a match search over the program characters.
// Restart: runs the one-cell-per-cycle tape clearing sweep before its result is given.
// Reset: async active low; a tape clearing pass follows, no input taken.
// Results wait in an output register; the next transaction is accepted meanwhile.
// ----------------------------------------------------------------------------
// bracket_loop_tape_machine
// Interpreter for the seven-operator tape language with program memory,
// byte tape memory, a sequencer and an output register.
// ----------------------------------------------------------------------------
module bracket_loop_tape_machine #(
  parameter int unsigned PROG_DEPTH = bltm_pkg::ProgDepthDef,
  parameter int unsigned TAPE_DEPTH = bltm_pkg::TapeDepthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire bltm_pkg::in_t  in_data_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      bltm_pkg::out_t out_data_o
);
  import bltm_pkg::*;

  localparam int unsigned PA = $clog2(PROG_DEPTH);
  localparam int unsigned DW = $clog2(TAPE_DEPTH);

  logic          prog_we;
  logic [PA-1:0] prog_waddr, prog_raddr;
  logic [7:0]    prog_wdata, prog_rdata;
  logic          tape_we;
  logic [DW-1:0] tape_waddr, tape_raddr;
  logic [7:0]    tape_wdata, tape_rdata;
  logic          res_free, res_push;
  out_t          res;

  bltm_ram #(
    .WIDTH(8),
    .DEPTH(PROG_DEPTH)
  ) u_prog_ram (
    .clk_i  (clk_i),
    .we_i   (prog_we),
    .waddr_i(prog_waddr),
    .wdata_i(prog_wdata),
    .raddr_i(prog_raddr),
    .rdata_o(prog_rdata)
  );

  bltm_ram #(
    .WIDTH(8),
    .DEPTH(TAPE_DEPTH)
  ) u_tape_ram (
    .clk_i  (clk_i),
    .we_i   (tape_we),
    .waddr_i(tape_waddr),
    .wdata_i(tape_wdata),
    .raddr_i(tape_raddr),
    .rdata_o(tape_rdata)
  );

  bltm_ctrl #(
    .PROG_DEPTH(PROG_DEPTH),
    .TAPE_DEPTH(TAPE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .prog_we_o   (prog_we),
    .prog_waddr_o(prog_waddr),
    .prog_wdata_o(prog_wdata),
    .prog_raddr_o(prog_raddr),
    .prog_rdata_i(prog_rdata),
    .tape_we_o   (tape_we),
    .tape_waddr_o(tape_waddr),
    .tape_wdata_o(tape_wdata),
    .tape_raddr_o(tape_raddr),
    .tape_rdata_i(tape_rdata),
    .res_free_i  (res_free),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  bltm_outreg u_outreg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .push_data_i(res),
    .free_o     (res_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bracket loop tape machine. A tracker class keeps
// its own copy of program memory, tape, program counter and data pointer. It
// works out the result of every accepted input transaction and compares each
// output transaction against the oldest result still due. Stimulus opens with
// a short directed program that touches every operator, pointer wrap and both
// unmatched bracket cases. Random well-formed and broken programs with noise
// transactions follow.
// ----------------------------------------------------------------------------
module tb_top;
  import bltm_pkg::*;

  localparam int unsigned ProgDepth = ProgDepthDef;
  localparam int unsigned TapeDepth = TapeDepthDef;
  localparam logic [1:0]  ActUnused = 2'd3;
  localparam int unsigned RandItems = 1150;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  class tape_tracker;
    logic [7:0]  prog_mem [ProgDepth];
    logic [7:0]  tape_mem [TapeDepth];
    int unsigned pc_q;
    int unsigned dp_q;
    bit          run_halted;
    out_t        due_results [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned prints;
    int unsigned halts;

    function new();
      foreach (prog_mem[a]) prog_mem[a] = CharNul;
      foreach (tape_mem[a]) tape_mem[a] = 8'h00;
      pc_q       = 0;
      dp_q       = 0;
      run_halted = 1'b0;
      errors     = 0;
      checked    = 0;
      prints     = 0;
      halts      = 0;
    endfunction

    // Find the close bracket that pairs with the open bracket at start.
    function bit match_close(int unsigned start, output int unsigned hit);
      int unsigned nest;
      int unsigned a;
      nest = 1;
      a    = start;
      hit  = 0;
      while (nest != 0) begin
        a++;
        if (a >= ProgDepth) return 1'b0;
        if (prog_mem[a] == CharNul) return 1'b0;
        if (prog_mem[a] == CharOpen) nest++;
        else if (prog_mem[a] == CharClose) nest--;
      end
      hit = a;
      return 1'b1;
    endfunction

    // Find the open bracket that pairs with the close bracket at start.
    // A zero character is just another non-bracket on the way back.
    function bit match_open(int unsigned start, output int unsigned hit);
      int unsigned nest;
      int unsigned a;
      nest = 1;
      a    = start;
      hit  = 0;
      while (nest != 0) begin
        if (a == 0) return 1'b0;
        a--;
        if (prog_mem[a] == CharOpen) nest--;
        else if (prog_mem[a] == CharClose) nest++;
      end
      hit = a;
      return 1'b1;
    endfunction

    function void execute_op(inout out_t res);
      logic [7:0]  op;
      logic [7:0]  cell_val;
      int unsigned hit;
      if (run_halted) return;
      op = (pc_q < ProgDepth) ? prog_mem[pc_q] : CharNul;
      if (op == CharNul) begin
        run_halted = 1'b1;
        return;
      end
      cell_val = tape_mem[dp_q];
      case (op)
        CharRight: dp_q = (dp_q + 1) % TapeDepth;
        CharLeft:  dp_q = (dp_q + TapeDepth - 1) % TapeDepth;
        CharInc:   tape_mem[dp_q] = cell_val + 8'd1;
        CharDec:   tape_mem[dp_q] = cell_val - 8'd1;
        CharOut: begin
          res.out_byte  = cell_val;
          res.out_valid = 1'b1;
        end
        CharOpen: begin
          if (cell_val == 8'h00) begin
            if (!match_close(pc_q, hit)) begin
              run_halted = 1'b1;
              return;
            end
            pc_q = hit;
          end
        end
        CharClose: begin
          if (cell_val != 8'h00) begin
            if (!match_open(pc_q, hit)) begin
              run_halted = 1'b1;
              return;
            end
            pc_q = hit;
          end
        end
        default: ;
      endcase
      pc_q++;
    endfunction

    function void note_command(in_t cmd);
      out_t res;
      res = '0;
      case (cmd.action)
        ActLoad: begin
          if (cmd.load_address < ProgDepth) prog_mem[cmd.load_address] = cmd.load_char;
        end
        ActRestart: begin
          foreach (tape_mem[a]) tape_mem[a] = 8'h00;
          pc_q       = 0;
          dp_q       = 0;
          run_halted = 1'b0;
        end
        ActStep: execute_op(res);
        default: ;
      endcase
      res.halted = run_halted;
      due_results.push_back(res);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH %s", what);
    endtask

    task check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing due: byte %0d valid %0d halted %0d",
                         got.out_byte, got.out_valid, got.halted));
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (want.out_valid) prints++;
      if (want.halted) halts++;
      if (got.out_byte !== want.out_byte)
        report($sformatf("result %0d out_byte: got %0d, want %0d",
                         checked, got.out_byte, want.out_byte));
      if (got.out_valid !== want.out_valid)
        report($sformatf("result %0d out_valid: got %0d, want %0d",
                         checked, got.out_valid, want.out_valid));
      if (got.halted !== want.halted)
        report($sformatf("result %0d halted: got %0d, want %0d",
                         checked, got.halted, want.halted));
    endtask
  endclass

  tape_tracker tracker;
  int unsigned sent_count = 0;
  int unsigned prog_len   = 0;
  int unsigned out_hold   = 0;
  bit          no_idle    = 1'b0;

  bracket_loop_tape_machine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Check each output transaction, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(out_data_o);
    if (out_hold != 0) begin
      out_hold--;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      out_hold = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic issue_cmd(input in_t cmd);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    tracker.note_command(cmd);
    sent_count++;
  endtask

  task automatic load_at(input logic [11:0] addr, input logic [7:0] ch);
    in_t cmd;
    cmd.action       = ActLoad;
    cmd.load_address = addr;
    cmd.load_char    = ch;
    issue_cmd(cmd);
  endtask

  task automatic restart_run();
    in_t cmd;
    cmd.action       = ActRestart;
    cmd.load_address = 12'($urandom);
    cmd.load_char    = 8'($urandom);
    issue_cmd(cmd);
  endtask

  task automatic step_once();
    in_t cmd;
    cmd.action       = ActStep;
    cmd.load_address = 12'($urandom);
    cmd.load_char    = 8'($urandom);
    issue_cmd(cmd);
  endtask

  // Load a program from address 0 and terminate it with a zero character.
  task automatic load_code(input logic [7:0] code_q [$]);
    foreach (code_q[i]) load_at(12'(i), code_q[i]);
    load_at(12'(code_q.size()), CharNul);
    prog_len = code_q.size();
  endtask

  initial begin
    in_t         cmd;
    logic [7:0]  code_q [$];
    logic [7:0]  ch;
    string       demo;
    int unsigned base;
    int unsigned budget;
    int unsigned len;
    int unsigned opens;
    int unsigned pick;
    int unsigned runs;
    bit          broken;

    tracker = new();
    runs    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: wrap left, print 255 and 0, skip a loop, skip a non-operator,
    // then a close bracket whose backward scan runs past address zero.
    demo = "<-.>.[+]x+]";
    for (int i = 0; i < demo.len(); i++) code_q.push_back(demo[i]);
    load_code(code_q);
    restart_run();
    repeat (10) step_once();
    // Rewrite the program mid-run so the open bracket finds no match.
    restart_run();
    repeat (5) step_once();
    load_at(12'd7, CharOpen);
    step_once();
    cmd.action       = ActUnused;
    cmd.load_address = 12'($urandom);
    cmd.load_char    = 8'($urandom);
    issue_cmd(cmd);
    step_once();
    // Program end right after the first operator.
    restart_run();
    load_at(12'd1, CharNul);
    step_once();
    step_once();

    // Random programs: mostly balanced brackets, some broken ones, plus noise.
    code_q.delete();
    base = sent_count;
    while (sent_count - base < RandItems) begin
      no_idle = (sent_count - base) >= RandItems * 7 / 8;
      broken  = ($urandom_range(0, 99) < 15);
      if (code_q.size() == 0 || $urandom_range(0, 9) != 0) begin
        code_q.delete();
        len   = $urandom_range(3, 20);
        opens = 0;
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 25) ch = CharInc;
          else if (pick < 40) ch = CharDec;
          else if (pick < 52) ch = CharRight;
          else if (pick < 64) ch = CharLeft;
          else if (pick < 79) ch = CharOut;
          else if (pick < 89) begin
            ch = CharOpen;
            opens++;
          end else if (pick < 95) begin
            if (opens != 0 || broken) begin
              ch = CharClose;
              if (opens != 0) opens--;
            end else begin
              ch = CharInc;
            end
          end else begin
            ch = 8'($urandom_range(1, 255));
            if (ch == CharOpen || ch == CharClose) ch = 8'h20;
          end
          code_q.push_back(ch);
        end
        if (!broken) begin
          while (opens != 0) begin
            code_q.push_back(CharClose);
            opens--;
          end
        end
        load_code(code_q);
      end
      restart_run();
      runs++;
      budget = $urandom_range(4, 32);
      repeat (budget) begin
        if (tracker.run_halted && $urandom_range(0, 1) == 0) break;
        if ($urandom_range(0, 11) == 0) begin
          cmd.load_address = 12'($urandom);
          cmd.load_char    = 8'($urandom);
          case ($urandom_range(0, 3))
            0, 1: begin
              // Keep the terminator zero so no unwritten entry is ever read.
              cmd.action = ActLoad;
              if (cmd.load_address == prog_len) cmd.load_char = CharNul;
            end
            2:       cmd.action = ActUnused;
            default: cmd.action = ActRestart;
          endcase
          issue_cmd(cmd);
        end
        step_once();
      end
    end

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TapeDepth + 64) @(posedge clk_i);

    $display("summary: %0d transactions in, %0d results checked, %0d prints, %0d halted",
             sent_count, tracker.checked, tracker.prints, tracker.halts);
    $display("summary: directed program plus %0d random program runs", runs);
    if (tracker.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout: results stopped arriving");
    $display("tb_top: errors");
    $finish;
  end

endmodule

[bracket_loop_tape_machine.f]
rtl/bltm_pkg.sv
rtl/bltm_ram.sv
rtl/bltm_outreg.sv
rtl/bltm_ctrl.sv
rtl/bracket_loop_tape_machine.sv
verif/tb_top.sv
